### rtl/hsm_pkg.sv
// ============================================================================
// hsm_pkg: shared types and constants for the hyperplane split margin block
// Holds default parameters, accumulator limits and the controller state type.
// ============================================================================
package hsm_pkg;

    localparam int MAX_DIM_DEF         = 128;
    localparam int COMPONENT_WIDTH_DEF = 16;

    localparam int ACC_W    = 48;
    localparam int MARGIN_W = 32;
    localparam int ROOT_W   = ACC_W / 2;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_PROD,
        ST_SQRT,
        ST_DIV,
        ST_FINISH,
        ST_OUT
    } hsm_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accum;       // latch an accepted component
        logic add_prod;    // add the registered products into the sums
        logic sqrt_init;
        logic sqrt_step;
        logic div_init;
        logic div_step;
        logic finish;      // form the margin and flags into the output register
        logic clear;       // clear the sums for the next vector
    } hsm_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sqrt_done;
        logic div_done;
    } hsm_stat_t;

endpackage

### rtl/hsm_datapath.sv
// ============================================================================
// hsm_datapath: accumulators, square root and divider
// Registers differences and products, keeps the saturating sums, and runs a
// bit-serial integer square root followed by a bit-serial restoring divide.
// ============================================================================
module hsm_datapath #(
    parameter int MAX_DIM         = hsm_pkg::MAX_DIM_DEF,
    parameter int COMPONENT_WIDTH = hsm_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  hsm_pkg::hsm_cmd_t                     cmd,
    output hsm_pkg::hsm_stat_t                    stat,
    input  logic signed [COMPONENT_WIDTH-1:0]     point_component,
    input  logic signed [COMPONENT_WIDTH-1:0]     left_component,
    input  logic signed [COMPONENT_WIDTH-1:0]     right_component,
    output logic signed [hsm_pkg::MARGIN_W-1:0]   margin,
    output logic                                  degenerate,
    output logic                                  too_long
);
    import hsm_pkg::*;

    localparam int DW    = COMPONENT_WIDTH + 1;
    localparam int PW    = 2 * DW;
    localparam int CNT_W = $clog2(MAX_DIM + 1);
    localparam int SQ_CW = $clog2(ROOT_W + 1);
    localparam int DV_CW = $clog2(ACC_W + 1);

    logic signed [DW-1:0]    dr_reg, dx_reg;
    logic signed [PW-1:0]    pdot_reg, pnsq_reg;
    logic                    pvalid_reg;
    logic signed [ACC_W-1:0] dot_reg, nsq_reg;
    logic [CNT_W-1:0]        count_reg;
    logic                    ovf_reg;

    // Square root (digit-by-digit, one result bit per step).
    logic [ACC_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [ACC_W-1:0]  sq_src_reg;
    logic [SQ_CW-1:0]  sq_cnt_reg;

    // Divider on the magnitude of the dot sum.
    logic [ACC_W-1:0]  dq_reg;      // dividend shifting into quotient
    logic [ROOT_W:0]   drem_reg;
    logic [DV_CW-1:0]  dv_cnt_reg;
    logic              dneg_reg;

    logic signed [MARGIN_W-1:0] margin_reg;
    logic                       degen_reg;
    logic                       long_reg;

    function automatic logic signed [ACC_W-1:0] clamp_prod(input logic signed [PW-1:0] p);
        logic signed [ACC_W+PW-1:0] w;
        begin
            w = (ACC_W+PW)'(p);
            if (w > (ACC_W+PW)'(ACC_MAX))      clamp_prod = ACC_MAX;
            else if (w < (ACC_W+PW)'(ACC_MIN)) clamp_prod = ACC_MIN;
            else                               clamp_prod = ACC_W'(w);
        end
    endfunction

    function automatic logic signed [ACC_W-1:0] add_sat(input logic signed [ACC_W-1:0] a,
                                                        input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] s;
        begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
            if (s[ACC_W] != s[ACC_W-1]) add_sat = s[ACC_W] ? ACC_MIN : ACC_MAX;
            else                        add_sat = s[ACC_W-1:0];
        end
    endfunction

    // Square root step: bring down two bits, try 4*root+1.
    logic [ACC_W-1:0]  sq_trial_rem;
    logic [ROOT_W+1:0] sq_trial;
    logic              sq_fit;
    always_comb begin
        sq_trial_rem = {rem_reg[ACC_W-3:0], sq_src_reg[ACC_W-1:ACC_W-2]};
        sq_trial     = {root_reg, 2'b01};
        sq_fit       = sq_trial_rem >= ACC_W'(sq_trial);
    end

    // Divide step.
    logic [ROOT_W+1:0] dv_shift;
    logic              dv_fit;
    always_comb begin
        dv_shift = {drem_reg, dq_reg[ACC_W-1]};
        dv_fit   = dv_shift >= (ROOT_W+2)'(root_reg);
    end

    logic signed [ACC_W+1:0] q_signed, m_wide;
    always_comb begin
        q_signed = dneg_reg ? -$signed({2'b00, dq_reg}) : $signed({2'b00, dq_reg});
        m_wide   = q_signed - $signed((ACC_W+2)'(root_reg >> 1));
    end

    always_ff @(posedge aclk) begin
        if (cmd.accum) begin
            dr_reg <= DW'(right_component) - DW'(left_component);
            dx_reg <= DW'(point_component) - DW'(left_component);
        end
        // A component past the length limit leaves zero products behind, so
        // the add that follows it changes nothing.
        if (pvalid_reg) begin
            pdot_reg <= dr_reg * dx_reg;
            pnsq_reg <= dr_reg * dr_reg;
        end else begin
            pdot_reg <= '0;
            pnsq_reg <= '0;
        end
        if (cmd.sqrt_init) begin
            rem_reg    <= '0;
            root_reg   <= '0;
            sq_src_reg <= nsq_reg;
        end else if (cmd.sqrt_step) begin
            rem_reg    <= sq_fit ? sq_trial_rem - ACC_W'(sq_trial) : sq_trial_rem;
            root_reg   <= {root_reg[ROOT_W-2:0], sq_fit};
            sq_src_reg <= {sq_src_reg[ACC_W-3:0], 2'b00};
        end
        if (cmd.div_init) begin
            dneg_reg <= dot_reg[ACC_W-1];
            dq_reg   <= dot_reg[ACC_W-1] ? ACC_W'(-dot_reg) : ACC_W'(dot_reg);
            drem_reg <= '0;
        end else if (cmd.div_step) begin
            drem_reg <= dv_fit ? (ROOT_W+1)'(dv_shift - (ROOT_W+2)'(root_reg))
                               : dv_shift[ROOT_W:0];
            dq_reg   <= {dq_reg[ACC_W-2:0], dv_fit};
        end
        if (cmd.finish) begin
            degen_reg <= (nsq_reg == '0);
            long_reg  <= ovf_reg;
            if (nsq_reg == '0)
                margin_reg <= '0;
            else if (m_wide > (ACC_W+2)'($signed({1'b0, {(MARGIN_W-1){1'b1}}})))
                margin_reg <= {1'b0, {(MARGIN_W-1){1'b1}}};
            else if (m_wide < -(ACC_W+2)'($signed({1'b0, 1'b1, {(MARGIN_W-1){1'b0}}})))
                margin_reg <= {1'b1, {(MARGIN_W-1){1'b0}}};
            else
                margin_reg <= MARGIN_W'(m_wide);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            dot_reg    <= '0;
            nsq_reg    <= '0;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            sq_cnt_reg <= '0;
            dv_cnt_reg <= '0;
        end else begin
            pvalid_reg <= cmd.accum && (count_reg < CNT_W'(MAX_DIM));
            if (cmd.accum) begin
                if (count_reg < CNT_W'(MAX_DIM)) begin
                    count_reg <= count_reg + 1'b1;
                end else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.add_prod) begin
                dot_reg <= add_sat(dot_reg, clamp_prod(pdot_reg));
                nsq_reg <= add_sat(nsq_reg, clamp_prod(pnsq_reg));
            end
            if (cmd.sqrt_init)      sq_cnt_reg <= '0;
            else if (cmd.sqrt_step) sq_cnt_reg <= sq_cnt_reg + 1'b1;
            if (cmd.div_init)       dv_cnt_reg <= '0;
            else if (cmd.div_step)  dv_cnt_reg <= dv_cnt_reg + 1'b1;
            if (cmd.clear) begin
                dot_reg   <= '0;
                nsq_reg   <= '0;
                count_reg <= '0;
                ovf_reg   <= 1'b0;
            end
        end
    end

    // The pending-product flag tells the controller nothing new: add_prod is always
    // accum passed through acc_d1_reg and acc_d2_reg, so it follows the products.
    assign stat.sqrt_done = (sq_cnt_reg == SQ_CW'(ROOT_W - 1)) && cmd.sqrt_step;
    assign stat.div_done  = (dv_cnt_reg == DV_CW'(ACC_W - 1)) && cmd.div_step;

    assign margin     = margin_reg;
    assign degenerate = degen_reg;
    assign too_long   = long_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_DIM)) else $error("component count beyond limit");
    a_nsq_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        !nsq_reg[ACC_W-1]) else $error("norm sum went negative");
    a_clear_sums: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.clear |=> (count_reg == '0) && !ovf_reg) else $error("clear failed");
endmodule

### rtl/hsm_ctrl.sv
// ============================================================================
// hsm_ctrl: sequencing controller
// Accepts components, waits out the product pipeline, runs root and divide,
// and holds the result until the output side takes it.
// ============================================================================
module hsm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic                s_tlast,
    output logic                m_tvalid,
    input  logic                m_tready,
    output hsm_pkg::hsm_cmd_t   cmd,
    input  hsm_pkg::hsm_stat_t  stat
);
    import hsm_pkg::*;

    hsm_state_t state_reg, state_next;
    logic       last_reg;
    logic       acc_d1_reg, acc_d2_reg;
    logic       accept;

    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_ACCUM:  if (accept && s_tlast) state_next = ST_PROD;
            ST_PROD:   if (!acc_d1_reg && !acc_d2_reg) state_next = ST_SQRT;
            ST_SQRT:   if (stat.sqrt_done) state_next = ST_DIV;
            ST_DIV:    if (stat.div_done) state_next = ST_FINISH;
            ST_FINISH: state_next = ST_OUT;
            ST_OUT:    if (m_tready) state_next = ST_ACCUM;
            default:   state_next = ST_ACCUM;
        endcase
    end

    always_comb begin
        s_tready      = (state_reg == ST_ACCUM);
        m_tvalid      = (state_reg == ST_OUT);
        cmd           = '0;
        cmd.accum     = accept;
        cmd.add_prod  = acc_d2_reg;
        cmd.sqrt_init = (state_reg == ST_PROD) && !acc_d1_reg && !acc_d2_reg;
        cmd.sqrt_step = (state_reg == ST_SQRT);
        cmd.div_init  = (state_reg == ST_SQRT) && stat.sqrt_done;
        cmd.div_step  = (state_reg == ST_DIV);
        cmd.finish    = (state_reg == ST_FINISH);
        cmd.clear     = (state_reg == ST_FINISH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_ACCUM;
            acc_d1_reg <= 1'b0;
            acc_d2_reg <= 1'b0;
            last_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_d1_reg <= accept;
            acc_d2_reg <= acc_d1_reg;
            if (accept) last_reg <= s_tlast;
        end
    end

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_ACCUM) |-> !accept) else $error("request taken while busy");
    a_last_goes: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (state_reg == ST_PROD)) else $error("missed last");
    a_out_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(state_reg) == ST_FINISH && last_reg)
        else $error("result without last");
endmodule

### rtl/hyperplane_split_margin.sv
// ============================================================================
// hyperplane_split_margin: signed distance from a pivot bisector plane
// Accumulates component products and emits margin = dot/|r-l| - |r-l|/2.
// ============================================================================
// One component is accepted per cycle while a vector streams in. After the
// component marked tlast the block takes no request while it drains the
// product pipeline, runs the bit-serial square root and the bit-serial
// divide and forms the result, then offers the result until m_tready.
module hyperplane_split_margin #(
    parameter int MAX_DIM         = hsm_pkg::MAX_DIM_DEF,
    parameter int COMPONENT_WIDTH = hsm_pkg::COMPONENT_WIDTH_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_tvalid,
    output logic s_tready,
    // point_component, left_component, right_component, then zero fill
    input  logic [((3*COMPONENT_WIDTH+7)/8)*8-1:0] s_tdata,
    input  logic s_tlast,
    output logic m_tvalid,
    input  logic m_tready,
    // margin
    output logic [hsm_pkg::MARGIN_W-1:0] m_tdata,
    // degenerate, too_long
    output logic [1:0] m_tuser
);
    import hsm_pkg::*;

    hsm_cmd_t  cmd;
    hsm_stat_t stat;
    logic signed [MARGIN_W-1:0] margin;
    logic degenerate, too_long;

    hsm_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cmd(cmd), .stat(stat)
    );

    hsm_datapath #(.MAX_DIM(MAX_DIM), .COMPONENT_WIDTH(COMPONENT_WIDTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .point_component(s_tdata[COMPONENT_WIDTH-1:0]),
        .left_component(s_tdata[2*COMPONENT_WIDTH-1:COMPONENT_WIDTH]),
        .right_component(s_tdata[3*COMPONENT_WIDTH-1:2*COMPONENT_WIDTH]),
        .margin(margin), .degenerate(degenerate), .too_long(too_long)
    );

    assign m_tdata = margin;
    assign m_tuser = {too_long, degenerate};
endmodule
